@@ sv/tgr_pkg.sv @@
// Shared constants, types and register codes of the text glyph renderer.
`default_nettype none
package tgr_pkg;

    // Font geometry
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int LINE_GAP     = 2;
    localparam int LINE_PITCH   = GLYPH_HEIGHT + LINE_GAP;

    // Printable range and control bytes
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd126;
    localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
    localparam logic [7:0] CHAR_TAB        = 8'd9;
    localparam int         TAB_STEP        = 4;

    // Glyph store: 95 characters of 16 rows each
    localparam int STORE_ROWS  = 16;
    localparam int ROW_W       = $clog2(STORE_ROWS);
    localparam int CHAR_W      = 7;
    localparam int STORE_DEPTH = 95 * STORE_ROWS;
    localparam int STORE_AW    = CHAR_W + ROW_W;

    // Field and register widths
    localparam int REG_W   = 13;
    localparam int ADDR_W  = 25;
    localparam int COL_W   = 11;
    localparam int LINE_W  = 9;
    localparam int PIX_W   = 14;
    localparam int PROD_W  = PIX_W + REG_W;

    localparam logic [COL_W-1:0]  COL_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [7:0] ROW_MASK = 8'(8'hFF << (8 - GLYPH_WIDTH));
    localparam logic [ROW_W-1:0] LAST_GLYPH_ROW = ROW_W'(GLYPH_HEIGHT - 1);

    // Configuration register indexes
    localparam logic REG_BUFFER_WIDTH  = 1'b0;
    localparam logic REG_BUFFER_HEIGHT = 1'b1;

    // Glyph store write request
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] index;
        logic [7:0]          bits;
    } t_tgr_load;

    // One glyph row read request towards the output pipe
    typedef struct packed {
        logic                valid;
        logic [STORE_AW-1:0] index;
        logic [ADDR_W-1:0]   addr;
        logic                last;
    } t_tgr_issue;

endpackage
`default_nettype wire

@@ sv/tgr_in_if.sv @@
// Input request channel: render byte or glyph row load.
`default_nettype none
interface tgr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       first_in_string;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] row_bits;

    modport source (output valid, func, first_in_string, char_code, glyph_row, row_bits,
                    input ready);
    modport sink   (input valid, func, first_in_string, char_code, glyph_row, row_bits,
                    output ready);
endinterface
`default_nettype wire

@@ sv/tgr_out_if.sv @@
// Output request channel: one glyph row with its buffer address.
`default_nettype none
interface tgr_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] pixel_address;
    logic [7:0]  row_pixels;
    logic        last_row;

    modport source (output valid, pixel_address, row_pixels, last_row, input ready);
    modport sink   (input valid, pixel_address, row_pixels, last_row, output ready);
endinterface
`default_nettype wire

@@ sv/tgr_row_pipe.sv @@
// Glyph store memory with its read stage and the output register.
`default_nettype none
module tgr_row_pipe (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tgr_pkg::t_tgr_load  i_load,
    input  wire tgr_pkg::t_tgr_issue i_issue,
    output logic                    o_issue_ready,
    tgr_out_if.source               o_out
);
    import tgr_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];

    logic              r_s1_valid;
    logic [7:0]        r_s1_data;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_last;

    logic              r_o_valid;
    logic [7:0]        r_o_pixels;
    logic [ADDR_W-1:0] r_o_addr;
    logic              r_o_last;

    logic out_free;
    logic s1_move;
    logic issue_fire;

    // Handshake between read stage and output register
    assign out_free      = !r_o_valid || o_out.ready;
    assign s1_move       = r_s1_valid && out_free;
    assign o_issue_ready = !r_s1_valid || s1_move;
    assign issue_fire    = i_issue.valid && o_issue_ready;

    // Glyph store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_load.en) begin
            r_mem[i_load.index] <= i_load.bits;
        end
        if (issue_fire) begin
            r_s1_data <= r_mem[i_issue.index];
            r_s1_addr <= i_issue.addr;
            r_s1_last <= i_issue.last;
        end
    end

    // Read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (issue_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_pixels <= r_s1_data & ROW_MASK;
            r_o_addr   <= r_s1_addr;
            r_o_last   <= r_s1_last;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.pixel_address = r_o_addr;
    assign o_out.row_pixels    = r_o_pixels;
    assign o_out.last_row      = r_o_last;

endmodule
`default_nettype wire

@@ sv/text_glyph_renderer.sv @@
// Text glyph renderer top level: cursor control, bounds check and row sequencing.
//
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      func, first_in_string, char_code, glyph_row, row_bits
//  o_out     out  valid/ready      pixel_address, row_pixels, last_row
//  cfg       in   i_cfg_we         i_cfg_idx, i_cfg_wdata
//
// A load request writes the glyph store and the block is ready again at once.
// A render request first goes through the bounds check and address multiply;
// a printable byte in bounds then issues one glyph row read per cycle while
// the read stage is ready, 16 rows, set by the single glyph store read port;
// the next request is taken after the last read issue. Output stalls back up
// through the read stage into the row sequencer. Synchronous active-low reset
// clears cursor, state and valid flags; the glyph store is not cleared.
`default_nettype none
module text_glyph_renderer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [tgr_pkg::REG_W-1:0]   i_cfg_wdata,
    tgr_in_if.sink                           i_in,
    tgr_out_if.source                        o_out
);
    import tgr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [REG_W-1:0]  r_width, r_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [LINE_W-1:0] r_line, n_line;
    logic [7:0]        r_code;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_addr, n_addr;

    logic              accept;
    logic              printable;
    logic              load_ok;
    logic [PIX_W-1:0]  col_px;
    logic [PIX_W-1:0]  line_px;
    logic [PROD_W-1:0] line_off;
    logic              out_of_bounds;
    logic [COL_W:0]    col_tab;
    logic [COL_W:0]    col_inc;
    logic [LINE_W:0]   line_inc;
    logic [CHAR_W-1:0] char_idx;
    logic              issue_ready;
    t_tgr_load         load;
    t_tgr_issue        issue;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Glyph row load
    assign load_ok    = (i_in.char_code >= FIRST_PRINTABLE)
                        && (i_in.char_code <= LAST_PRINTABLE);
    assign load.en    = accept && i_in.func && load_ok;
    assign load.index = {CHAR_W'(i_in.char_code - FIRST_PRINTABLE), i_in.glyph_row};
    assign load.bits  = i_in.row_bits;

    // Bounds check and base address of the current cursor cell
    assign col_px        = PIX_W'(r_col) * PIX_W'(GLYPH_WIDTH);
    assign line_px       = PIX_W'(r_line) * PIX_W'(LINE_PITCH);
    assign line_off      = PROD_W'(line_px) * PROD_W'(r_width);
    assign out_of_bounds = (col_px >= PIX_W'(r_width)) || (line_px >= PIX_W'(r_height));
    assign printable     = (r_code >= FIRST_PRINTABLE) && (r_code <= LAST_PRINTABLE);
    assign char_idx      = CHAR_W'(r_code - FIRST_PRINTABLE);

    // Saturating cursor steps
    assign col_tab  = (COL_W+1)'(r_col) + (COL_W+1)'(TAB_STEP);
    assign col_inc  = (COL_W+1)'(r_col) + (COL_W+1)'(1);
    assign line_inc = (LINE_W+1)'(r_line) + (LINE_W+1)'(1);

    // Row read request
    assign issue.valid = (r_state == ST_EMIT);
    assign issue.index = {char_idx, r_row};
    assign issue.addr  = r_addr;
    assign issue.last  = (r_row == LAST_GLYPH_ROW);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_line  = r_line;
        n_row   = r_row;
        n_addr  = r_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_in.func) begin
                    n_state = ST_CHECK;
                    if (i_in.first_in_string) begin
                        n_col  = '0;
                        n_line = '0;
                    end
                end
            end
            ST_CHECK: begin
                n_state = ST_IDLE;
                if (!out_of_bounds) begin
                    priority if (r_code == CHAR_NEWLINE) begin
                        n_col  = '0;
                        n_line = line_inc[LINE_W] ? LINE_MAX : line_inc[LINE_W-1:0];
                    end else if (r_code == CHAR_TAB) begin
                        n_col = (col_tab > (COL_W+1)'(COL_MAX)) ? COL_MAX
                                                                 : col_tab[COL_W-1:0];
                    end else if (printable) begin
                        n_state = ST_EMIT;
                        n_row   = '0;
                        n_addr  = ADDR_W'(col_px) + ADDR_W'(line_off);
                        n_col   = col_inc[COL_W] ? COL_MAX : col_inc[COL_W-1:0];
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (issue_ready) begin
                    n_row  = r_row + ROW_W'(1);
                    n_addr = r_addr + ADDR_W'(r_width);
                    if (issue.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_line  <= n_line;
        end
    end

    // Request payload and row counters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= i_in.char_code;
        end
        r_row  <= n_row;
        r_addr <= n_addr;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= REG_W'(640);
            r_height <= REG_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BUFFER_WIDTH:  r_width  <= i_cfg_wdata;
                REG_BUFFER_HEIGHT: r_height <= i_cfg_wdata;
                default:           r_width  <= r_width;
            endcase
        end
    end

    tgr_row_pipe u_row_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_issue       (issue),
        .o_issue_ready (issue_ready),
        .o_out         (o_out)
    );

endmodule
`default_nettype wire
